@@ hdl/wpf_pkg.sv @@
// ----------------------------------------------------------------------------
// wpf_pkg
// Shared types, constants and the digit matcher of the wildcard packet filter.
// ----------------------------------------------------------------------------
package wpf_pkg;

    localparam int MAX_RULES_DEF = 64;
    localparam int ADDR_DIGITS   = 8;
    localparam int DIGITS_W      = 32;
    localparam int WILD_W        = 8;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_CHECK  = 2'd2;

    // Rule write broadcast to every cell.
    typedef struct packed {
        logic                en;
        logic                permits;
        logic [DIGITS_W-1:0] src_digits;
        logic [WILD_W-1:0]   src_wild;
        logic [DIGITS_W-1:0] dst_digits;
        logic [WILD_W-1:0]   dst_wild;
    } rule_wr_t;

    // Packet check moving one cell per cycle along the chain.
    typedef struct packed {
        logic                valid;
        logic [DIGITS_W-1:0] src_digits;
        logic [DIGITS_W-1:0] dst_digits;
        logic                accepted;
    } probe_t;

    function automatic logic pattern_match(
        input logic [WILD_W-1:0]   wild,
        input logic [DIGITS_W-1:0] digits,
        input logic [DIGITS_W-1:0] addr
    );
        logic hit;
        hit = 1'b1;
        for (int i = 0; i < WILD_W; i++) begin
            if (i < ADDR_DIGITS && !wild[WILD_W-1-i]
                && digits[DIGITS_W-1-4*i -: 4] != addr[DIGITS_W-1-4*i -: 4]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

@@ hdl/wpf_in_if.sv @@
// ----------------------------------------------------------------------------
// wpf_in_if
// Command channel of the wildcard packet filter.
// ----------------------------------------------------------------------------
interface wpf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        rule_permits;
    logic [31:0] src_digits;
    logic [7:0]  src_wild;
    logic [31:0] dst_digits;
    logic [7:0]  dst_wild;

    modport source (output valid, func, rule_permits, src_digits, src_wild,
                    dst_digits, dst_wild, input ready);
    modport sink   (input valid, func, rule_permits, src_digits, src_wild,
                    dst_digits, dst_wild, output ready);
endinterface

@@ hdl/wpf_out_if.sv @@
// ----------------------------------------------------------------------------
// wpf_out_if
// Result channel of the wildcard packet filter.
// ----------------------------------------------------------------------------
interface wpf_out_if;
    logic valid;
    logic ready;
    logic accepted;
    logic status;

    modport source (output valid, accepted, status, input ready);
    modport sink   (input valid, accepted, status, output ready);
endinterface

@@ hdl/wildcard_packet_filter.sv @@
// ----------------------------------------------------------------------------
// wildcard_packet_filter
// Last-match-wins packet filter built as a chain of rule cells.
// ----------------------------------------------------------------------------
// A clear, append or unused command registers its result in the cycle after its
// transfer. A packet check walks the chain of MAX_RULES cells, one cell per
// cycle, and its result is registered as it leaves the last cell; the command port
// takes no new command while a check is in the chain. A later cell overrides
// the decision of an earlier one, which makes the latest matching rule win.
// ----------------------------------------------------------------------------
module wildcard_packet_filter #(
    parameter int MAX_RULES = wpf_pkg::MAX_RULES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    wpf_in_if.sink    cmd,
    wpf_out_if.source rsp
);

    localparam int CW = $clog2(MAX_RULES + 1);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              busy_reg;
    logic              res_valid_reg;
    logic              res_accepted_reg;
    logic              res_status_reg;
    logic              cmd_xfer;
    logic              full;
    wpf_pkg::rule_wr_t wr;
    wpf_pkg::probe_t   probe [MAX_RULES+1];

    assign cmd.ready = !busy_reg && (!res_valid_reg || rsp.ready);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign full      = count_reg == CW'(MAX_RULES);

    assign wr.en         = cmd_xfer && cmd.func == wpf_pkg::FUNC_APPEND && !full;
    assign wr.permits    = cmd.rule_permits;
    assign wr.src_digits = cmd.src_digits;
    assign wr.src_wild   = cmd.src_wild;
    assign wr.dst_digits = cmd.dst_digits;
    assign wr.dst_wild   = cmd.dst_wild;

    assign probe[0].valid      = cmd_xfer && cmd.func == wpf_pkg::FUNC_CHECK;
    assign probe[0].src_digits = cmd.src_digits;
    assign probe[0].dst_digits = cmd.dst_digits;
    assign probe[0].accepted   = 1'b0;

    for (genvar g = 0; g < MAX_RULES; g++)
    begin : g_cell
        wpf_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr        (wr),
            .count     (count_reg),
            .probe_in  (probe[g]),
            .probe_out (probe[g+1])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd_xfer)
        begin
            unique case (cmd.func)
                wpf_pkg::FUNC_CLEAR:  count_next = '0;
                wpf_pkg::FUNC_APPEND: if (!full) count_next = count_reg + CW'(1);
                default:              count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            busy_reg         <= 1'b0;
            res_valid_reg    <= 1'b0;
            res_accepted_reg <= 1'b0;
            res_status_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (rsp.valid && rsp.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (probe[MAX_RULES].valid)
            begin
                busy_reg         <= 1'b0;
                res_valid_reg    <= 1'b1;
                res_accepted_reg <= probe[MAX_RULES].accepted;
                res_status_reg   <= 1'b0;
            end
            else if (cmd_xfer)
            begin
                if (cmd.func == wpf_pkg::FUNC_CHECK)
                begin
                    busy_reg <= 1'b1;
                end
                else
                begin
                    res_valid_reg    <= 1'b1;
                    res_accepted_reg <= 1'b0;
                    res_status_reg   <= cmd.func == wpf_pkg::FUNC_APPEND && full;
                end
            end
        end
    end

    assign rsp.valid    = res_valid_reg;
    assign rsp.accepted = res_accepted_reg;
    assign rsp.status   = res_status_reg;

    // No command is taken while a check is in the chain.
    a_no_cmd_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |-> !busy_reg)
        else $error("command transfer while a check is in flight");

    // The rule count never exceeds the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RULES))
        else $error("rule count beyond table size");

    // A check leaving the chain always belongs to a busy period.
    a_probe_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        probe[MAX_RULES].valid |-> busy_reg && !res_valid_reg)
        else $error("check result with no check in flight or result pending");

    // A check transfer makes the block busy in the next cycle.
    a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
        probe[0].valid |=> busy_reg)
        else $error("check transfer did not start a busy period");

endmodule

@@ hdl/wpf_cell.sv @@
// ----------------------------------------------------------------------------
// wpf_cell
// One rule slot. It stores a rule when addressed and updates the decision of
// the packet check that passes through it.
// ----------------------------------------------------------------------------
module wpf_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wpf_pkg::rule_wr_t wr,
    input  logic [CW-1:0]     count,
    input  wpf_pkg::probe_t   probe_in,
    output wpf_pkg::probe_t   probe_out
);

    logic [wpf_pkg::DIGITS_W-1:0] src_digits_reg;
    logic [wpf_pkg::WILD_W-1:0]   src_wild_reg;
    logic [wpf_pkg::DIGITS_W-1:0] dst_digits_reg;
    logic [wpf_pkg::WILD_W-1:0]   dst_wild_reg;
    logic                         permits_reg;
    logic                         probe_valid_reg;
    logic [wpf_pkg::DIGITS_W-1:0] probe_src_reg;
    logic [wpf_pkg::DIGITS_W-1:0] probe_dst_reg;
    logic                         probe_accepted_reg;
    wpf_pkg::probe_t              probe_next;
    logic                         active;
    logic                         hit;

    assign active = count > CW'(IDX);
    assign hit = active
        && wpf_pkg::pattern_match(src_wild_reg, src_digits_reg, probe_in.src_digits)
        && wpf_pkg::pattern_match(dst_wild_reg, dst_digits_reg, probe_in.dst_digits);

    always_comb
    begin
        probe_next = probe_in;
        if (hit)
        begin
            probe_next.accepted = permits_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && count == CW'(IDX))
        begin
            src_digits_reg <= wr.src_digits;
            src_wild_reg   <= wr.src_wild;
            dst_digits_reg <= wr.dst_digits;
            dst_wild_reg   <= wr.dst_wild;
            permits_reg    <= wr.permits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_valid_reg <= 1'b0;
        end
        else
        begin
            probe_valid_reg <= probe_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_src_reg      <= probe_next.src_digits;
        probe_dst_reg      <= probe_next.dst_digits;
        probe_accepted_reg <= probe_next.accepted;
    end

    assign probe_out.valid      = probe_valid_reg;
    assign probe_out.src_digits = probe_src_reg;
    assign probe_out.dst_digits = probe_dst_reg;
    assign probe_out.accepted   = probe_accepted_reg;

endmodule

@@ tb/wildcard_packet_filter_tb.sv @@
// ----------------------------------------------------------------------------
// wildcard_packet_filter_tb
// Self-checking testbench for the last-match-wins wildcard packet filter.
// ----------------------------------------------------------------------------
// Commands go in through the command channel with random gaps, and results come
// back through the result channel with random stalls. A scoreboard class keeps
// its own copy of the rule table, works out the expected accept/status answer
// for every command transfer, and compares each result transfer with the
// oldest pending answer. A short directed sequence covers wildcards, raw
// non-decimal nibbles, packet wildcard bits, rule override order, the unused
// command code and a full table. It is followed by random traffic that mostly
// checks packets built to hit stored rules.
// ----------------------------------------------------------------------------
module wildcard_packet_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RULE_SLOTS   = wpf_pkg::MAX_RULES_DEF;
    localparam int         RANDOM_ITEMS = 1730;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         DRAIN_CYCLES = 2 * RULE_SLOTS + 20;
    localparam logic [1:0] FUNC_SPARE   = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic        permits;
        logic [31:0] src;
        logic [7:0]  src_wild;
        logic [31:0] dst;
        logic [7:0]  dst_wild;
    } filter_cmd_t;

    typedef struct packed {
        logic accepted;
        logic status;
    } verdict_t;

    class verdict_board;
        logic [39:0] src_rules [RULE_SLOTS];
        logic [39:0] dst_rules [RULE_SLOTS];
        logic        rule_permit [RULE_SLOTS];
        int          rule_total;
        verdict_t    pending [$];
        int          faults;

        function new();
            rule_total = 0;
            faults     = 0;
        endfunction

        function bit rule_hits(logic [39:0] pat, logic [31:0] addr);
            for (int i = 0; i < wpf_pkg::ADDR_DIGITS; i++) begin
                if (!pat[39-i] && pat[31-4*i -: 4] !== addr[31-4*i -: 4])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_transfer(filter_cmd_t c);
            verdict_t v;
            v = '0;
            case (c.func)
                wpf_pkg::FUNC_CLEAR: rule_total = 0;
                wpf_pkg::FUNC_APPEND:
                begin
                    if (rule_total >= RULE_SLOTS) begin
                        v.status = 1'b1;
                    end else begin
                        src_rules[rule_total]   = {c.src_wild, c.src};
                        dst_rules[rule_total]   = {c.dst_wild, c.dst};
                        rule_permit[rule_total] = c.permits;
                        rule_total++;
                    end
                end
                wpf_pkg::FUNC_CHECK:
                begin
                    for (int k = rule_total - 1; k >= 0; k--) begin
                        if (rule_hits(src_rules[k], c.src) && rule_hits(dst_rules[k], c.dst))
                        begin
                            v.accepted = rule_permit[k];
                            break;
                        end
                    end
                end
                default: ;
            endcase
            pending.push_back(v);
        endfunction

        function void check_result(logic accepted, logic status);
            verdict_t v;
            if (pending.size() == 0) begin
                faults++;
                $display("%0t: unexpected result, expected none, got accepted=%0b status=%0b",
                         $time, accepted, status);
                return;
            end
            v = pending.pop_front();
            if (accepted !== v.accepted) begin
                faults++;
                $display("%0t: accepted mismatch, expected %0b, got %0b",
                         $time, v.accepted, accepted);
            end
            if (status !== v.status) begin
                faults++;
                $display("%0t: status mismatch, expected %0b, got %0b",
                         $time, v.status, status);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    wpf_in_if  cmd_if ();
    wpf_out_if rsp_if ();

    wildcard_packet_filter u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if.sink),
        .rsp   (rsp_if.source)
    );

    verdict_board board;
    int           sent_count;
    int           idle_cycles;
    bit           sender_idles;
    bit           receiver_idles;
    bit           hold_request;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic filter_cmd_t make_cmd(logic [1:0] func, logic permits,
                                             logic [31:0] src, logic [7:0] src_wild,
                                             logic [31:0] dst, logic [7:0] dst_wild);
        filter_cmd_t c;
        c.func     = func;
        c.permits  = permits;
        c.src      = src;
        c.src_wild = src_wild;
        c.dst      = dst;
        c.dst_wild = dst_wild;
        return c;
    endfunction

    function automatic logic [31:0] pick_digits();
        logic [31:0] d;
        d = $urandom;
        if ($urandom_range(0, 1) == 0) begin
            for (int i = 0; i < 8; i++)
                d[4*i +: 4] = 4'($urandom_range(0, 9));
        end
        return d;
    endfunction

    function automatic logic [7:0] pick_wild();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'($urandom_range(0, 255));
            2: return 8'($urandom_range(0, 255) & $urandom_range(0, 255));
            default: return 8'($urandom_range(0, 255) | $urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] address_for(logic [39:0] pat);
        logic [31:0] addr;
        int          idx;
        addr = pat[31:0];
        for (int i = 0; i < 8; i++) begin
            if (pat[39-i])
                addr[31-4*i -: 4] = 4'($urandom_range(0, 15));
        end
        if ($urandom_range(0, 5) == 0) begin
            idx = $urandom_range(0, 7);
            addr[31-4*idx -: 4] = addr[31-4*idx -: 4] ^ 4'($urandom_range(1, 15));
        end
        return addr;
    endfunction

    function automatic filter_cmd_t random_rule();
        return make_cmd(wpf_pkg::FUNC_APPEND, 1'($urandom_range(0, 1)), pick_digits(),
                        pick_wild(), pick_digits(), pick_wild());
    endfunction

    function automatic filter_cmd_t random_check();
        int k;
        if (board.rule_total > 0 && $urandom_range(0, 4) != 0) begin
            k = $urandom_range(0, board.rule_total - 1);
            return make_cmd(wpf_pkg::FUNC_CHECK, 1'($urandom_range(0, 1)),
                            address_for(board.src_rules[k]), 8'($urandom_range(0, 255)),
                            address_for(board.dst_rules[k]), 8'($urandom_range(0, 255)));
        end
        return make_cmd(wpf_pkg::FUNC_CHECK, 1'($urandom_range(0, 1)), pick_digits(),
                        8'($urandom_range(0, 255)), pick_digits(), 8'($urandom_range(0, 255)));
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_cmd(filter_cmd_t c);
        int gap;
        if ($urandom_range(0, 99) == 0)
            sender_idles = !sender_idles;
        gap = sender_idles ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.func         <= c.func;
        cmd_if.rule_permits <= c.permits;
        cmd_if.src_digits   <= c.src;
        cmd_if.src_wild     <= c.src_wild;
        cmd_if.dst_digits   <= c.dst;
        cmd_if.dst_wild     <= c.dst_wild;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        board.note_transfer(c);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic fill_table();
        repeat (RULE_SLOTS + 2)
            send_cmd(random_rule());
        repeat (4)
            send_cmd(random_check());
    endtask

    initial
    begin
        filter_cmd_t directed [$];
        int          roll;
        bit          hold_done;
        bit          pause_done;

        board               = new();
        sent_count          = 0;
        sender_idles        = 1'b1;
        receiver_idles      = 1'b1;
        hold_request        = 1'b0;
        hold_done           = 1'b0;
        pause_done          = 1'b0;
        rst_n               = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.func         = wpf_pkg::FUNC_CLEAR;
        cmd_if.rule_permits = 1'b0;
        cmd_if.src_digits   = '0;
        cmd_if.src_wild     = '0;
        cmd_if.dst_digits   = '0;
        cmd_if.dst_wild     = '0;
        rsp_if.ready        = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed.push_back(make_cmd(wpf_pkg::FUNC_CHECK, 1'b1, 32'h12345678, 8'h00,
                                    32'h87654321, 8'h00));
        directed.push_back(make_cmd(FUNC_SPARE, 1'b1, '1, '1, '1, '1));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CLEAR, 1'b1, '1, '1, '1, '1));
        directed.push_back(make_cmd(wpf_pkg::FUNC_APPEND, 1'b1, 32'h12345678, 8'h00,
                                    32'h87654321, 8'h00));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CHECK, 1'b0, 32'h12345678, 8'h00,
                                    32'h87654321, 8'h00));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CHECK, 1'b0, 32'h12345679, 8'h00,
                                    32'h87654321, 8'h00));
        directed.push_back(make_cmd(wpf_pkg::FUNC_APPEND, 1'b0, '1, 8'hFF, '1, 8'hFF));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CHECK, 1'b1, 32'h12345678, 8'h00,
                                    32'h87654321, 8'h00));
        directed.push_back(make_cmd(wpf_pkg::FUNC_APPEND, 1'b1, 32'hFFFFFFFF, 8'h00,
                                    32'h00000000, 8'h00));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CHECK, 1'b0, 32'hFFFFFFFF, 8'h00,
                                    32'h00000000, 8'h00));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CHECK, 1'b0, 32'hFFFFFFFE, 8'h00,
                                    32'h00000000, 8'h00));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CHECK, 1'b0, 32'hAAAAAAAA, 8'hFF,
                                    32'h00000000, 8'hFF));
        directed.push_back(make_cmd(wpf_pkg::FUNC_APPEND, 1'b1, 32'h12340000, 8'h0F,
                                    32'h00005555, 8'hF0));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CHECK, 1'b0, 32'h12349999, 8'h00,
                                    32'h77775555, 8'h00));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CHECK, 1'b0, 32'h12359999, 8'h00,
                                    32'h77775555, 8'h00));
        directed.push_back(make_cmd(FUNC_SPARE, 1'b0, 32'h0, 8'h0, 32'h0, 8'h0));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CLEAR, 1'b0, 32'h0, 8'h0, 32'h0, 8'h0));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CHECK, 1'b1, 32'h12349999, 8'hFF,
                                    32'h77775555, 8'hFF));
        directed.push_back(make_cmd(wpf_pkg::FUNC_APPEND, 1'b1, 32'hA5A5A5A5, 8'hAA,
                                    32'h5A5A5A5A, 8'h55));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CHECK, 1'b0, 32'h05F5B5C5, 8'h00,
                                    32'h5F5D5E5A, 8'h00));
        directed.push_back(make_cmd(wpf_pkg::FUNC_APPEND, 1'b0, 32'h0, 8'h0, 32'h0, 8'h0));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CHECK, 1'b1, 32'h0, 8'h0, 32'h0, 8'h0));
        directed.push_back(make_cmd(wpf_pkg::FUNC_CHECK, 1'b1, 32'hA5A5A5A5, 8'h0,
                                    32'h5A5A5A5A, 8'h0));
        foreach (directed[i])
            send_cmd(directed[i]);

        // A full table is reached at least once; further fills come at random.
        fill_table();
        send_cmd(make_cmd(wpf_pkg::FUNC_CLEAR, 1'b0, '0, '0, '0, '0));

        while (sent_count < directed.size() + RANDOM_ITEMS) begin
            if (!hold_done && sent_count >= 300) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && sent_count >= 900) begin
                cmd_if.valid <= 1'b0;
                while (board.pending.size() != 0)
                    @(negedge clk);
                pause_done = 1'b1;
            end
            roll = $urandom_range(0, 999);
            if (roll < 30)
                send_cmd(make_cmd(wpf_pkg::FUNC_CLEAR, 1'($urandom_range(0, 1)), $urandom,
                                  pick_wild(), $urandom, pick_wild()));
            else if (roll < 33)
                fill_table();
            else if (roll < 55)
                send_cmd(make_cmd(FUNC_SPARE, 1'($urandom_range(0, 1)), $urandom, pick_wild(),
                                  $urandom, pick_wild()));
            else if (roll < 420)
                send_cmd(random_rule());
            else
                send_cmd(random_check());
        end
        cmd_if.valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.faults == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 99) == 0)
                receiver_idles = !receiver_idles;
            if (hold_request) begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = receiver_idles ? $urandom_range(0, 13) : 0;
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
            board.check_result(rsp_if.accepted, rsp_if.status);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

endmodule
